>>> rtl/core/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master byte engine package
// Shared types and constants for the command queue and the bus engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned DELAY_W       = 18;
  localparam int unsigned UNIT_W        = 16;
  localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd100;

  // request codes on the request field
  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_RSTART = 3'd1;
  localparam logic [2:0] REQ_STOP  = 3'd2;
  localparam logic [2:0] REQ_WRITE = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_RSTART,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_kind_e;

  // one tick as seen by the engine
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] tx_data;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  // one result, last member in the lowest bit
  typedef struct packed {
    logic [7:0] rx_data;
    logic       ack_seen;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } res_t;

endpackage

>>> rtl/core/i2cm_front.sv
// ----------------------------------------------------------------------------
// I2C master front end
// Unpacks an input transaction and classifies its command.
// ----------------------------------------------------------------------------
module i2cm_front import i2cm_pkg::*; (
  input  logic       cmd_valid_i,
  input  logic [2:0] req_type_i,
  input  logic [7:0] tx_data_i,
  input  logic       send_ack_i,
  input  logic       sda_in_i,
  output tick_t      tick_o
);

  cmd_kind_e kind;

  always_comb begin
    kind = CMD_NONE;
    if (cmd_valid_i) begin
      unique case (req_type_i)
        REQ_START:  kind = CMD_START;
        REQ_RSTART: kind = CMD_RSTART;
        REQ_STOP:   kind = CMD_STOP;
        REQ_WRITE:  kind = CMD_WRITE;
        REQ_READ:   kind = CMD_READ;
        default:    kind = CMD_NONE;
      endcase
    end
  end

  assign tick_o.kind     = kind;
  assign tick_o.tx_data  = tx_data_i;
  assign tick_o.send_ack = send_ack_i;
  assign tick_o.sda_in   = sda_in_i;

endmodule

>>> rtl/core/i2cm_queue.sv
// ----------------------------------------------------------------------------
// I2C master tick queue
// Two-entry queue between the front end and the bus engine.
// ----------------------------------------------------------------------------
module i2cm_queue import i2cm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  tick_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output tick_t pop_data_o
);

  tick_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> rtl/core/i2cm_engine.sv
// ----------------------------------------------------------------------------
// I2C master bus engine
// Steps the bus sequencer once per queued tick and registers the result.
// ----------------------------------------------------------------------------
module i2cm_engine import i2cm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [UNIT_W-1:0] cfg_wdata_i,
  input  logic              tick_valid_i,
  input  tick_t             tick_i,
  output logic              tick_pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output res_t              res_o
);

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_ST_A      = 5'd1;
  localparam logic [4:0] PH_ST_B      = 5'd2;
  localparam logic [4:0] PH_RS_A      = 5'd3;
  localparam logic [4:0] PH_RS_B      = 5'd4;
  localparam logic [4:0] PH_RS_C      = 5'd5;
  localparam logic [4:0] PH_SP_A      = 5'd6;
  localparam logic [4:0] PH_SP_B      = 5'd7;
  localparam logic [4:0] PH_WR_LOW    = 5'd8;
  localparam logic [4:0] PH_WR_DATA   = 5'd9;
  localparam logic [4:0] PH_WR_HIGH   = 5'd10;
  localparam logic [4:0] PH_WA_REL    = 5'd11;
  localparam logic [4:0] PH_WA_SAMPLE = 5'd12;
  localparam logic [4:0] PH_WA_END    = 5'd13;
  localparam logic [4:0] PH_RD_LOW    = 5'd14;
  localparam logic [4:0] PH_RD_REL    = 5'd15;
  localparam logic [4:0] PH_RD_HIGH   = 5'd16;
  localparam logic [4:0] PH_RD_SAMPLE = 5'd17;
  localparam logic [4:0] PH_RD_FALL   = 5'd18;
  localparam logic [4:0] PH_RA_DRIVE  = 5'd19;
  localparam logic [4:0] PH_RA_HIGH   = 5'd20;
  localparam logic [4:0] PH_RA_END    = 5'd21;

  logic [UNIT_W-1:0]  unit_q, unit_d;
  logic [4:0]         phase_q, phase_d;
  logic [3:0]         bit_cnt_q, bit_cnt_d;
  logic [DELAY_W-1:0] delay_q, delay_d;
  logic [7:0]         shift_q, shift_d;
  logic               scl_q, scl_d;
  logic               sda_q, sda_d;
  logic               ack_flag_q, ack_flag_d;
  logic               ack_choice_q, ack_choice_d;
  logic [7:0]         rx_q, rx_d;
  logic               res_valid_q, res_valid_d;
  res_t               res_q, res_d;

  logic               step;
  logic               done;
  logic               do_enter;
  logic [4:0]         enter;
  logic [4:0]         nxt;
  logic               two_units;
  logic [DELAY_W-1:0] dly;
  logic [DELAY_W-1:0] unit_ext;
  logic [3:0]         cnt_inc;

  assign step       = tick_valid_i && (!res_valid_q || res_ready_i);
  assign tick_pop_o = step;
  assign unit_d     = cfg_we_i ? cfg_wdata_i : unit_q;
  assign unit_ext   = (unit_q == '0) ? DELAY_W'(1) : DELAY_W'(unit_q);
  assign cnt_inc    = bit_cnt_q + 4'd1;

  always_comb begin
    phase_d      = phase_q;
    bit_cnt_d    = bit_cnt_q;
    delay_d      = delay_q;
    shift_d      = shift_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    ack_flag_d   = ack_flag_q;
    ack_choice_d = ack_choice_q;
    rx_d         = rx_q;
    done         = 1'b0;
    do_enter     = 1'b0;
    enter        = PH_IDLE;
    nxt          = PH_IDLE;
    two_units    = 1'b0;
    dly          = delay_q;
    if (step) begin
      if (phase_q == PH_IDLE) begin
        if (tick_i.kind != CMD_NONE) begin
          bit_cnt_d = 4'd0;
          do_enter  = 1'b1;
          unique case (tick_i.kind)
            CMD_START:  enter = PH_ST_A;
            CMD_RSTART: enter = PH_RS_A;
            CMD_STOP:   enter = PH_SP_A;
            CMD_WRITE: begin
              shift_d = tick_i.tx_data;
              enter   = PH_WR_LOW;
            end
            CMD_READ: begin
              shift_d      = 8'd0;
              ack_choice_d = tick_i.send_ack;
              enter        = PH_RD_LOW;
            end
            default: do_enter = 1'b0;
          endcase
        end
      end else begin
        dly     = (delay_q != '0) ? delay_q - DELAY_W'(1) : delay_q;
        delay_d = dly;
        if (dly == '0) begin
          unique case (phase_q)
            PH_ST_A:      nxt = PH_ST_B;
            PH_RS_A:      nxt = PH_RS_B;
            PH_RS_B:      nxt = PH_RS_C;
            PH_SP_A:      nxt = PH_SP_B;
            PH_WR_LOW:    nxt = PH_WR_DATA;
            PH_WR_DATA:   nxt = PH_WR_HIGH;
            PH_WR_HIGH: begin
              shift_d   = {shift_q[6:0], 1'b0};
              bit_cnt_d = cnt_inc;
              nxt = (cnt_inc < 4'(BITS_PER_BYTE)) ? PH_WR_LOW : PH_WA_REL;
            end
            PH_WA_REL:    nxt = PH_WA_SAMPLE;
            PH_WA_SAMPLE: nxt = PH_WA_END;
            PH_RD_LOW:    nxt = PH_RD_REL;
            PH_RD_REL:    nxt = PH_RD_HIGH;
            PH_RD_HIGH:   nxt = PH_RD_SAMPLE;
            PH_RD_SAMPLE: nxt = PH_RD_FALL;
            PH_RD_FALL: begin
              bit_cnt_d = cnt_inc;
              nxt = (cnt_inc < 4'(BITS_PER_BYTE)) ? PH_RD_HIGH : PH_RA_DRIVE;
            end
            PH_RA_DRIVE:  nxt = PH_RA_HIGH;
            PH_RA_HIGH:   nxt = PH_RA_END;
            PH_RA_END: begin
              rx_d = shift_q;
              nxt  = PH_IDLE;
            end
            default:      nxt = PH_IDLE;
          endcase
          if (nxt == PH_IDLE) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end else begin
            do_enter = 1'b1;
            enter    = nxt;
          end
        end
      end
      if (do_enter) begin
        phase_d = enter;
        unique case (enter)
          PH_ST_A:      ;
          PH_ST_B:      sda_d = 1'b0;
          PH_RS_A:      sda_d = 1'b1;
          PH_RS_B:      scl_d = 1'b1;
          PH_RS_C:      sda_d = 1'b0;
          PH_SP_A:      scl_d = 1'b1;
          PH_SP_B:      sda_d = 1'b1;
          PH_WR_LOW:    scl_d = 1'b0;
          PH_WR_DATA:   sda_d = shift_d[7];
          PH_WR_HIGH: begin
            scl_d     = 1'b1;
            two_units = 1'b1;
          end
          PH_WA_REL: begin
            scl_d     = 1'b0;
            sda_d     = 1'b1;
            two_units = 1'b1;
          end
          PH_WA_SAMPLE: begin
            scl_d      = 1'b1;
            ack_flag_d = !tick_i.sda_in;
            two_units  = 1'b1;
          end
          PH_WA_END, PH_RA_END: begin
            scl_d     = 1'b0;
            sda_d     = 1'b0;
            two_units = 1'b1;
          end
          PH_RD_LOW:    scl_d = 1'b0;
          PH_RD_REL:    sda_d = 1'b1;
          PH_RD_HIGH:   scl_d = 1'b1;
          PH_RD_SAMPLE: shift_d = {shift_d[6:0], tick_i.sda_in};
          PH_RD_FALL: begin
            scl_d     = 1'b0;
            two_units = 1'b1;
          end
          PH_RA_DRIVE:  sda_d = !ack_choice_d;
          PH_RA_HIGH: begin
            scl_d     = 1'b1;
            two_units = 1'b1;
          end
          default: ;
        endcase
        delay_d = two_units ? {unit_ext[DELAY_W-2:0], 1'b0} : unit_ext;
      end
    end
  end

  always_comb begin
    res_d.rx_data  = rx_d;
    res_d.ack_seen = ack_flag_d;
    res_d.done_res = done;
    res_d.busy_res = (phase_d != PH_IDLE);
    res_d.sda_out  = sda_d;
    res_d.scl_out  = scl_d;
    res_valid_d    = step ? 1'b1 : (res_ready_i ? 1'b0 : res_valid_q);
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q       <= UNIT_RESET;
      phase_q      <= PH_IDLE;
      bit_cnt_q    <= 4'd0;
      delay_q      <= '0;
      shift_q      <= 8'd0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      ack_flag_q   <= 1'b0;
      ack_choice_q <= 1'b0;
      rx_q         <= 8'd0;
      res_valid_q  <= 1'b0;
    end else begin
      unit_q       <= unit_d;
      phase_q      <= phase_d;
      bit_cnt_q    <= bit_cnt_d;
      delay_q      <= delay_d;
      shift_q      <= shift_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      ack_flag_q   <= ack_flag_d;
      ack_choice_q <= ack_choice_d;
      rx_q         <= rx_d;
      res_valid_q  <= res_valid_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.done_res |-> !res_q.busy_res)
    else $error("done result still shows busy");

  a_idle_no_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> delay_q == '0)
    else $error("idle with delay pending");

  a_bit_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q <= 4'(BITS_PER_BYTE))
    else $error("bit counter past byte length");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> phase_q == $past(phase_q) && delay_q == $past(delay_q))
    else $error("engine advanced without a tick");

endmodule

>>> rtl/core/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// I2C master byte engine
// Tick-stepped I2C master for start, repeated start, stop and byte transfers.
// ----------------------------------------------------------------------------
// Each input transaction is one bus tick: tuser carries the command flag and
// request code, tdata the byte to send, the ACK choice and the sampled SDA.
// A command is taken only while the engine is idle; otherwise it is dropped.
// Each input transaction yields exactly one output transaction with the SCL
// and SDA drive levels, busy, done, acknowledge seen and the received byte.
// Throughput is one tick per cycle while the receiver takes results; the
// sequencer is combinational. A result passes through the tick queue and then
// the output register before it is offered.
// When the receiver stalls, the output register holds, the engine holds and
// the queue fills; s_axis_tready_o falls once both queue entries are taken.
// The delay unit must be written via cfg_we_i/cfg_wdata_i only while idle;
// the block does not enforce it. Zero counts as one. Reset releases SCL and
// SDA high, sets the unit to 100 ticks, empties the queue and output register.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine import i2cm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [UNIT_W-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [15:0]       s_axis_tdata_i,  // tx_data[7:0], send_ack, sda_in
  input  logic [3:0]        s_axis_tuser_i,  // cmd_valid, req_type[2:0]
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [15:0]       m_axis_tdata_o   // scl_out, sda_out, busy_res,
                                             // done_res, ack_seen, rx_data[7:0]
);

  tick_t front_tick;
  tick_t queue_tick;
  logic  queue_full;
  logic  queue_valid;
  logic  queue_pop;
  res_t  res;

  i2cm_front u_front (
    .cmd_valid_i (s_axis_tuser_i[0]),
    .req_type_i  (s_axis_tuser_i[3:1]),
    .tx_data_i   (s_axis_tdata_i[7:0]),
    .send_ack_i  (s_axis_tdata_i[8]),
    .sda_in_i    (s_axis_tdata_i[9]),
    .tick_o      (front_tick)
  );

  i2cm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i),
    .push_data_i (front_tick),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_tick)
  );

  i2cm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .tick_valid_i (queue_valid),
    .tick_i       (queue_tick),
    .tick_pop_o   (queue_pop),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (res)
  );

  assign s_axis_tready_o = !queue_full;
  assign m_axis_tdata_o  = {3'b000, res};

endmodule

>>> test/i2c_master_byte_engine_tb.sv
// ----------------------------------------------------------------------------
// I2C master byte engine testbench
// Streams bus ticks into the engine and checks every result transaction
// against a tick-accurate predictor of the sequencer held in a scoreboard.
// Covers start, repeated start, stop, write and read bytes, unknown requests,
// commands offered while busy, delay units from zero up to the largest value,
// and phases with sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_tb;
  import i2cm_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SDA_LOW     = 0;
  localparam int SDA_HIGH    = 1;
  localparam int SDA_RAND    = 2;

  typedef enum logic [4:0] {
    SEG_IDLE,
    SEG_ST_A, SEG_ST_B,
    SEG_RS_A, SEG_RS_B, SEG_RS_C,
    SEG_SP_A, SEG_SP_B,
    SEG_WR_LOW, SEG_WR_DATA, SEG_WR_HIGH,
    SEG_WA_REL, SEG_WA_SAMPLE, SEG_WA_END,
    SEG_RD_LOW, SEG_RD_REL, SEG_RD_HIGH, SEG_RD_SAMPLE, SEG_RD_FALL,
    SEG_RA_DRIVE, SEG_RA_HIGH, SEG_RA_END
  } seg_e;

  class tick_scoreboard;
    logic [UNIT_W-1:0]  unit_ticks;
    seg_e               seg;
    logic [3:0]         bit_cnt;
    logic [DELAY_W-1:0] dly;
    logic [7:0]         shreg;
    logic               scl;
    logic               sda;
    logic               ack_flag;
    logic               ack_choice;
    logic [7:0]         rx_byte;
    res_t               bus_levels_q[$];
    int                 errors;
    int                 res_count;

    function new();
      unit_ticks = UNIT_RESET;
      seg        = SEG_IDLE;
      bit_cnt    = '0;
      dly        = '0;
      shreg      = '0;
      scl        = 1'b1;
      sda        = 1'b1;
      ack_flag   = 1'b0;
      ack_choice = 1'b0;
      rx_byte    = '0;
      errors     = 0;
      res_count  = 0;
    endfunction

    function void set_unit(logic [UNIT_W-1:0] value);
      unit_ticks = value;
    endfunction

    function bit busy();
      return seg != SEG_IDLE;
    endfunction

    function int pending();
      return bus_levels_q.size();
    endfunction

    function void enter(seg_e p, logic sda_s);
      int units;
      units = 1;
      seg = p;
      case (p)
        SEG_ST_B:      sda = 1'b0;
        SEG_RS_A:      sda = 1'b1;
        SEG_RS_B:      scl = 1'b1;
        SEG_RS_C:      sda = 1'b0;
        SEG_SP_A:      scl = 1'b1;
        SEG_SP_B:      sda = 1'b1;
        SEG_WR_LOW:    scl = 1'b0;
        SEG_WR_DATA:   sda = shreg[7];
        SEG_WR_HIGH: begin
          scl = 1'b1;
          units = 2;
        end
        SEG_WA_REL: begin
          scl = 1'b0;
          sda = 1'b1;
          units = 2;
        end
        SEG_WA_SAMPLE: begin
          scl = 1'b1;
          ack_flag = ~sda_s;
          units = 2;
        end
        SEG_WA_END: begin
          scl = 1'b0;
          sda = 1'b0;
          units = 2;
        end
        SEG_RD_LOW:    scl = 1'b0;
        SEG_RD_REL:    sda = 1'b1;
        SEG_RD_HIGH:   scl = 1'b1;
        SEG_RD_SAMPLE: shreg = {shreg[6:0], sda_s};
        SEG_RD_FALL: begin
          scl = 1'b0;
          units = 2;
        end
        SEG_RA_DRIVE:  sda = ~ack_choice;
        SEG_RA_HIGH: begin
          scl = 1'b1;
          units = 2;
        end
        SEG_RA_END: begin
          scl = 1'b0;
          sda = 1'b0;
          units = 2;
        end
        default: ;
      endcase
      dly = DELAY_W'(units * ((unit_ticks == '0) ? 32'd1 : 32'(unit_ticks)));
    endfunction

    function seg_e advance(seg_e p);
      case (p)
        SEG_ST_A:      return SEG_ST_B;
        SEG_RS_A:      return SEG_RS_B;
        SEG_RS_B:      return SEG_RS_C;
        SEG_SP_A:      return SEG_SP_B;
        SEG_WR_LOW:    return SEG_WR_DATA;
        SEG_WR_DATA:   return SEG_WR_HIGH;
        SEG_WR_HIGH: begin
          shreg = shreg << 1;
          bit_cnt = bit_cnt + 4'd1;
          return (bit_cnt < BITS_PER_BYTE) ? SEG_WR_LOW : SEG_WA_REL;
        end
        SEG_WA_REL:    return SEG_WA_SAMPLE;
        SEG_WA_SAMPLE: return SEG_WA_END;
        SEG_RD_LOW:    return SEG_RD_REL;
        SEG_RD_REL:    return SEG_RD_HIGH;
        SEG_RD_HIGH:   return SEG_RD_SAMPLE;
        SEG_RD_SAMPLE: return SEG_RD_FALL;
        SEG_RD_FALL: begin
          bit_cnt = bit_cnt + 4'd1;
          return (bit_cnt < BITS_PER_BYTE) ? SEG_RD_HIGH : SEG_RA_DRIVE;
        end
        SEG_RA_DRIVE:  return SEG_RA_HIGH;
        SEG_RA_HIGH:   return SEG_RA_END;
        SEG_RA_END: begin
          rx_byte = shreg;
          return SEG_IDLE;
        end
        default:       return SEG_IDLE;
      endcase
    endfunction

    // predict the result of one accepted tick
    function void note_tick(logic [15:0] tdata, logic [3:0] tuser);
      logic       cmd;
      logic [2:0] req;
      logic       sda_s;
      logic       done;
      seg_e       nxt;
      res_t       r;
      cmd   = tuser[0];
      req   = tuser[3:1];
      sda_s = tdata[9];
      done  = 1'b0;
      if (seg == SEG_IDLE) begin
        if (cmd && req <= REQ_READ) begin
          bit_cnt = '0;
          case (req)
            REQ_START:  enter(SEG_ST_A, sda_s);
            REQ_RSTART: enter(SEG_RS_A, sda_s);
            REQ_STOP:   enter(SEG_SP_A, sda_s);
            REQ_WRITE: begin
              shreg = tdata[7:0];
              enter(SEG_WR_LOW, sda_s);
            end
            default: begin
              shreg = '0;
              ack_choice = tdata[8];
              enter(SEG_RD_LOW, sda_s);
            end
          endcase
        end
      end else begin
        if (dly != '0) dly = dly - 1'b1;
        if (dly == '0) begin
          nxt = advance(seg);
          if (nxt == SEG_IDLE) begin
            seg = SEG_IDLE;
            done = 1'b1;
          end else begin
            enter(nxt, sda_s);
          end
        end
      end
      r.scl_out  = scl;
      r.sda_out  = sda;
      r.busy_res = (seg != SEG_IDLE);
      r.done_res = done;
      r.ack_seen = ack_flag;
      r.rx_data  = rx_byte;
      bus_levels_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 40) $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [15:0] tdata);
      res_t got;
      res_t want;
      got = res_t'(tdata[12:0]);
      res_count++;
      if (bus_levels_q.size() == 0) begin
        report($sformatf("result %0d arrived with no tick waiting", res_count));
        return;
      end
      want = bus_levels_q.pop_front();
      if (got.scl_out !== want.scl_out)
        report($sformatf("result %0d scl_out %b, want %b", res_count, got.scl_out,
                         want.scl_out));
      if (got.sda_out !== want.sda_out)
        report($sformatf("result %0d sda_out %b, want %b", res_count, got.sda_out,
                         want.sda_out));
      if (got.busy_res !== want.busy_res)
        report($sformatf("result %0d busy_res %b, want %b", res_count, got.busy_res,
                         want.busy_res));
      if (got.done_res !== want.done_res)
        report($sformatf("result %0d done_res %b, want %b", res_count, got.done_res,
                         want.done_res));
      if (got.ack_seen !== want.ack_seen)
        report($sformatf("result %0d ack_seen %b, want %b", res_count, got.ack_seen,
                         want.ack_seen));
      if (got.rx_data !== want.rx_data)
        report($sformatf("result %0d rx_data %h, want %h", res_count, got.rx_data,
                         want.rx_data));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [UNIT_W-1:0] cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;
  logic [3:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [15:0]       m_axis_tdata;

  tick_scoreboard sb = new();
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int tick_count = 0;
  int quiet_cycles = 0;

  i2c_master_byte_engine DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("i2c_master_byte_engine_tb: errors");
    $finish;
  end

  function automatic logic pick_sda(int mode);
    return (mode == SDA_RAND) ? 1'($urandom) : (mode == SDA_HIGH);
  endfunction

  // offer one tick and hold it until the transaction completes
  task automatic send_tick(input logic cmd, input logic [2:0] req, input logic [7:0] txd,
                           input logic ack, input logic sda_s);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, sda_s, ack, txd};
    s_axis_tuser  <= {req, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick({6'b0, sda_s, ack, txd}, {req, cmd});
    tick_count++;
    @(negedge clk_i);
  endtask

  // issue a command, then tick until the engine is idle again
  task automatic issue_cmd(input logic [2:0] req, input logic [7:0] txd, input logic ack,
                           input int sda_mode, input int noise_pct);
    send_tick(1'b1, req, txd, ack, pick_sda(sda_mode));
    while (sb.busy())
      send_tick($urandom_range(99) < noise_pct, 3'($urandom_range(7)), 8'($urandom),
                1'($urandom), pick_sda(sda_mode));
  endtask

  task automatic random_byte(input int noise_pct);
    if ($urandom_range(1))
      issue_cmd(REQ_WRITE, 8'($urandom), 1'($urandom), SDA_RAND, noise_pct);
    else
      issue_cmd(REQ_READ, 8'($urandom), 1'($urandom), SDA_RAND, noise_pct);
  endtask

  task automatic run_frame(input int noise_pct);
    int n;
    n = $urandom_range(1, 3);
    issue_cmd(REQ_START, 8'($urandom), 1'($urandom), SDA_RAND, noise_pct);
    repeat (n) random_byte(noise_pct);
    if ($urandom_range(4) == 0) begin
      issue_cmd(REQ_RSTART, 8'($urandom), 1'($urandom), SDA_RAND, noise_pct);
      random_byte(noise_pct);
    end
    issue_cmd(REQ_STOP, 8'($urandom), 1'($urandom), SDA_RAND, noise_pct);
  endtask

  // drain all results, then write the delay unit
  task automatic write_unit(input logic [UNIT_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    sb.set_unit(value);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct,
                           input logic [UNIT_W-1:0] value, input int target);
    int unsigned r;
    int          stop_at;
    write_unit(value);
    sender_idle_pct = snd_pct;
    recv_stall_pct  = rcv_pct;
    stop_at = tick_count + target;
    while (tick_count < stop_at) begin
      r = $urandom_range(99);
      if (r < 70)
        run_frame(20);
      else if (r < 85)
        issue_cmd(3'($urandom_range(7)), 8'($urandom), 1'($urandom), SDA_RAND, 20);
      else
        repeat ($urandom_range(1, 5))
          send_tick(1'b0, 3'($urandom_range(7)), 8'($urandom), 1'($urandom),
                    1'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset delay unit
    issue_cmd(REQ_START, 8'h00, 1'b0, SDA_RAND, 0);

    // zero unit counts as one
    write_unit('0);
    send_tick(1'b0, 3'($urandom_range(7)), 8'hFF, 1'b1, 1'b1);
    send_tick(1'b0, 3'($urandom_range(7)), 8'h00, 1'b0, 1'b0);
    issue_cmd(REQ_START, 8'h00, 1'b0, SDA_RAND, 0);
    issue_cmd(REQ_WRITE, 8'hFF, 1'b0, SDA_LOW, 0);
    issue_cmd(REQ_WRITE, 8'h00, 1'b1, SDA_HIGH, 100);
    issue_cmd(REQ_WRITE, 8'hA5, 1'b0, SDA_RAND, 50);
    issue_cmd(REQ_READ, 8'hFF, 1'b1, SDA_HIGH, 0);
    issue_cmd(REQ_READ, 8'h00, 1'b0, SDA_LOW, 100);
    issue_cmd(REQ_RSTART, 8'hFF, 1'b1, SDA_RAND, 0);
    issue_cmd(REQ_READ, 8'h5A, 1'b1, SDA_RAND, 30);
    issue_cmd(REQ_STOP, 8'h00, 1'b0, SDA_RAND, 100);
    for (int c = REQ_READ + 1; c < 8; c++) issue_cmd(3'(c), 8'($urandom), 1'($urandom),
                                                      SDA_RAND, 0);
    issue_cmd(REQ_STOP, 8'hFF, 1'b1, SDA_HIGH, 0);

    run_phase(0, 0, 16'd2, 60);
    run_phase(86, 0, 16'd1, 60);
    run_phase(0, 86, 16'd1, 60);
    run_phase(9, 9, 16'($urandom_range(1, 2)), 60);

    // largest delay unit, start of one sequence with commands offered while busy
    write_unit('1);
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_tick(1'b1, REQ_STOP, 8'($urandom), 1'($urandom), 1'($urandom));
    repeat (40)
      send_tick(1'b1, 3'($urandom_range(7)), 8'($urandom), 1'($urandom),
                1'($urandom));

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0)
      $display("i2c_master_byte_engine_tb: clean");
    else
      $display("i2c_master_byte_engine_tb: errors");
    $finish;
  end

endmodule

>>> i2c_master_byte_engine.f
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_front.sv
rtl/core/i2cm_queue.sv
rtl/core/i2cm_engine.sv
rtl/core/i2c_master_byte_engine.sv
test/i2c_master_byte_engine_tb.sv
